/* hdl/mswg_pkg.sv */
package mswg_pkg;

   typedef enum logic [2:0] {
      WAVE_SINE     = 3'd0,
      WAVE_TRIANGLE = 3'd1,
      WAVE_SAWTOOTH = 3'd2,
      WAVE_SQUARE   = 3'd3,
      WAVE_ZERO     = 3'd4
   } shape_sel_type;

   localparam int SAMPLE_W = 8;
   localparam int PHASE_W  = 12;
   localparam int SELECT_W = 3;

   localparam int DEFAULT_SAMPLES_PER_PERIOD = 256;
   localparam int DEFAULT_AMPLITUDE          = 255;

   localparam logic [63:0] PI_Q30  = 64'd3373259426;
   localparam logic [63:0] ONE_Q30 = 64'd1073741824;

   typedef logic [63:0] taylor_div_type [1:7];
   localparam taylor_div_type TAYLOR_DIV = '{64'd6, 64'd20, 64'd42, 64'd72,
                                             64'd110, 64'd156, 64'd210};

endpackage

/* hdl/multi_shape_waveform_generator_top.sv */
// Lookup-table waveform generator, one DAC sample per request word.
// Request channel (req_valid/req_ready, req_restart): each word is one sample
// tick; req_restart forces phase 0 for this tick. Response channel
// (rsp_valid/rsp_ready): one word per request with the DAC code, the phase
// index of the sample and a flag on the last sample of a period.
// csr_wr_en/csr_wr_data write wave_select: 0 sine, 1 triangle, 2 sawtooth,
// 3 square, 4 and above zero. Write it only while no word is in flight.
// Throughput is one word per cycle while the receiver keeps up and no fill
// pass runs. An accepted request is registered in the read stage (shape table
// read and phase register), then moves into the output register once that is
// free; rsp_valid is the output register's valid bit.
// The shape table holds sine, triangle and sawtooth codes per phase in one
// RAM. After reset a fill pass copies the build-time table into it, one entry
// per cycle; req_ready stays low until it completes. Reset sets phase 0 and
// wave_select to zero output.
// When the receiver stalls, one word waits in the output register and one in
// the read stage; the request side keeps going until both are full.
module multi_shape_waveform_generator_top #(
   parameter int SAMPLES_PER_PERIOD = mswg_pkg::DEFAULT_SAMPLES_PER_PERIOD,
   parameter int AMPLITUDE          = mswg_pkg::DEFAULT_AMPLITUDE
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_restart,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [mswg_pkg::SAMPLE_W-1:0] rsp_sample,
   output logic [mswg_pkg::PHASE_W-1:0]  rsp_phase,
   output logic                          rsp_period_end,
   input  logic                          csr_wr_en,
   input  logic [mswg_pkg::SELECT_W-1:0] csr_wr_data
);

   localparam int N   = SAMPLES_PER_PERIOD;
   localparam int AW  = $clog2(N);
   localparam int SW  = mswg_pkg::SAMPLE_W;
   localparam int PW  = mswg_pkg::PHASE_W;
   localparam int RW  = 3 * SW;

   localparam logic [63:0] U_Q   = 64'h1_0000_0000 / N;
   localparam logic [63:0] U_R   = 64'h1_0000_0000 % N;
   localparam int          SAW_Q = AMPLITUDE / N;
   localparam int          SAW_R = AMPLITUDE % N;
   localparam int          TRI_Q = (2 * AMPLITUDE) / N;
   localparam int          TRI_R = (2 * AMPLITUDE) % N;

   typedef logic [RW-1:0] rom_type [N];

   function automatic logic [SW-1:0] sine_code(logic [63:0] turn);
      logic [63:0] u;
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] term;
      logic [63:0] num;
      logic [63:0] code;
      longint      s;
      logic        neg;
      u   = turn;
      neg = 1'b0;
      if (u >= 64'h8000_0000) begin
         neg = 1'b1;
         u   = u - 64'h8000_0000;
      end
      if (u > 64'h4000_0000) begin
         u = 64'h8000_0000 - u;
      end
      x    = (u * mswg_pkg::PI_Q30) >> 31;
      x2   = (x * x) >> 30;
      term = x;
      s    = longint'(term);
      for (int k = 1; k <= 7; k++) begin
         term = ((term * x2) >> 30) / mswg_pkg::TAYLOR_DIV[k];
         if (k % 2 == 1) begin
            s = s - longint'(term);
         end else begin
            s = s + longint'(term);
         end
      end
      if (s < 0) begin
         s = 0;
      end
      if (s > longint'(mswg_pkg::ONE_Q30)) begin
         s = longint'(mswg_pkg::ONE_Q30);
      end
      if (neg) begin
         s = -s;
      end
      num  = 64'(longint'(mswg_pkg::ONE_Q30) + s) * 64'(AMPLITUDE);
      code = (num + mswg_pkg::ONE_Q30) >> 31;
      if (code > 64'd255) begin
         code = 64'd255;
      end
      return SW'(code);
   endfunction

   function automatic rom_type build_rom();
      rom_type     rom;
      logic [63:0] u_acc;
      logic [63:0] u_rem;
      int          saw_acc;
      int          saw_rem;
      int          tri_acc;
      int          tri_rem;
      int          tri_val;
      u_acc   = 64'd0;
      u_rem   = 64'd0;
      saw_acc = 0;
      saw_rem = 0;
      tri_acc = 0;
      tri_rem = 0;
      for (int i = 0; i < N; i++) begin
         if (i > N / 2) begin
            tri_val = 2 * AMPLITUDE - tri_acc - ((tri_rem != 0) ? 1 : 0);
         end else begin
            tri_val = tri_acc;
         end
         rom[i] = {sine_code(u_acc), SW'(tri_val), SW'(saw_acc)};
         u_acc   = u_acc + U_Q;
         u_rem   = u_rem + U_R;
         if (u_rem >= 64'(N)) begin
            u_rem = u_rem - 64'(N);
            u_acc = u_acc + 64'd1;
         end
         saw_acc = saw_acc + SAW_Q;
         saw_rem = saw_rem + SAW_R;
         if (saw_rem >= N) begin
            saw_rem = saw_rem - N;
            saw_acc = saw_acc + 1;
         end
         tri_acc = tri_acc + TRI_Q;
         tri_rem = tri_rem + TRI_R;
         if (tri_rem >= N) begin
            tri_rem = tri_rem - N;
            tri_acc = tri_acc + 1;
         end
      end
      return rom;
   endfunction

   localparam rom_type ROM = build_rom();

   localparam logic [AW-1:0] LAST_PHASE = AW'(N - 1);
   localparam logic [AW-1:0] HALF_PHASE = AW'(N / 2);

   logic                         fill_busy_ff;
   logic                         fill_busy_in;
   logic [AW-1:0]                fill_addr_ff;
   logic [AW-1:0]                fill_addr_in;
   logic [mswg_pkg::SELECT_W-1:0] wave_ff;
   logic [mswg_pkg::SELECT_W-1:0] wave_in;
   logic [AW-1:0]                phase_ff;
   logic [AW-1:0]                phase_in;
   logic                         s1_valid_ff;
   logic                         s1_valid_in;
   logic [AW-1:0]                s1_phase_ff;
   logic [AW-1:0]                s1_phase_in;
   logic                         rsp_valid_ff;
   logic                         rsp_valid_in;
   logic [SW-1:0]                rsp_sample_ff;
   logic [SW-1:0]                rsp_sample_in;
   logic [PW-1:0]                rsp_phase_ff;
   logic [PW-1:0]                rsp_phase_in;
   logic                         rsp_period_end_ff;
   logic                         rsp_period_end_in;

   logic          accept;
   logic          s1_adv;
   logic [AW-1:0] idx;
   logic [RW-1:0] rd_data;
   logic [SW-1:0] sample;

   mswg_ram #(
      .WIDTH(RW),
      .DEPTH(N)
   ) u_table (
      .clock  (clock),
      .wr_en  (fill_busy_ff),
      .wr_addr(fill_addr_ff),
      .wr_data(ROM[fill_addr_ff]),
      .rd_en  (accept),
      .rd_addr(idx),
      .rd_data(rd_data)
   );

   assign s1_adv    = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !fill_busy_ff && (!s1_valid_ff || s1_adv);
   assign accept    = req_valid && req_ready;
   assign idx       = req_restart ? '0 : phase_ff;

   always_comb begin
      unique case (wave_ff)
         mswg_pkg::WAVE_SINE:     sample = rd_data[3*SW-1:2*SW];
         mswg_pkg::WAVE_TRIANGLE: sample = rd_data[2*SW-1:SW];
         mswg_pkg::WAVE_SAWTOOTH: sample = rd_data[SW-1:0];
         mswg_pkg::WAVE_SQUARE:   sample = (s1_phase_ff < HALF_PHASE) ? SW'(AMPLITUDE) : '0;
         default:                 sample = '0;
      endcase
   end

   always_comb begin
      fill_busy_in      = fill_busy_ff;
      fill_addr_in      = fill_addr_ff;
      wave_in           = wave_ff;
      phase_in          = phase_ff;
      s1_valid_in       = s1_valid_ff;
      s1_phase_in       = s1_phase_ff;
      rsp_valid_in      = rsp_valid_ff;
      rsp_sample_in     = rsp_sample_ff;
      rsp_phase_in      = rsp_phase_ff;
      rsp_period_end_in = rsp_period_end_ff;

      if (fill_busy_ff) begin
         if (fill_addr_ff == LAST_PHASE) begin
            fill_busy_in = 1'b0;
         end else begin
            fill_addr_in = fill_addr_ff + 1'b1;
         end
      end

      if (csr_wr_en) begin
         wave_in = csr_wr_data;
      end

      // advance the word in the read stage into the output register
      if (s1_adv) begin
         rsp_valid_in      = 1'b1;
         rsp_sample_in     = sample;
         rsp_phase_in      = PW'(s1_phase_ff);
         rsp_period_end_in = (s1_phase_ff == LAST_PHASE);
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (accept) begin
         s1_valid_in = 1'b1;
         s1_phase_in = idx;
         phase_in    = (idx == LAST_PHASE) ? '0 : idx + 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_busy_ff <= 1'b1;
         fill_addr_ff <= '0;
         wave_ff      <= mswg_pkg::WAVE_ZERO;
         phase_ff     <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fill_busy_ff <= fill_busy_in;
         fill_addr_ff <= fill_addr_in;
         wave_ff      <= wave_in;
         phase_ff     <= phase_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_phase_ff       <= s1_phase_in;
      rsp_sample_ff     <= rsp_sample_in;
      rsp_phase_ff      <= rsp_phase_in;
      rsp_period_end_ff <= rsp_period_end_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample     = rsp_sample_ff;
   assign rsp_phase      = rsp_phase_ff;
   assign rsp_period_end = rsp_period_end_ff;

endmodule

/* hdl/mswg_ram.sv */
module mswg_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* sim/testbench.sv */
module testbench;

   localparam int PERIOD_LEN = 256;
   localparam int AMP        = 255;

   localparam logic [mswg_pkg::SELECT_W-1:0] SEL_SPARE_LO  = 3'd5;
   localparam logic [mswg_pkg::SELECT_W-1:0] SEL_SPARE_MID = 3'd6;
   localparam logic [mswg_pkg::SELECT_W-1:0] SEL_SPARE_HI  = 3'd7;

   localparam longint unsigned PI_FIX   = 64'd3373259426;
   localparam longint unsigned UNIT_FIX = 64'd1 << 30;

   localparam int HOLD_CYCLES = 40;

   typedef struct packed {
      logic [mswg_pkg::SAMPLE_W-1:0] sample;
      logic [mswg_pkg::PHASE_W-1:0]  phase;
      logic                          period_end;
   } tick_type;

   typedef struct packed {
      bit                            write_sel;
      logic [mswg_pkg::SELECT_W-1:0] sel;
      bit                            restart;
      bit                            typed;
      logic [mswg_pkg::SAMPLE_W-1:0] sample;
      logic [mswg_pkg::PHASE_W-1:0]  phase;
      logic                          period_end;
   } row_type;

   logic                          clock;
   logic                          reset;
   logic                          req_valid;
   logic                          req_ready;
   logic                          req_restart;
   logic                          rsp_valid;
   logic                          rsp_ready;
   logic [mswg_pkg::SAMPLE_W-1:0] rsp_sample;
   logic [mswg_pkg::PHASE_W-1:0]  rsp_phase;
   logic                          rsp_period_end;
   logic                          csr_wr_en;
   logic [mswg_pkg::SELECT_W-1:0] csr_wr_data;

   logic [mswg_pkg::SAMPLE_W-1:0] sine_codes [PERIOD_LEN];
   logic [mswg_pkg::SELECT_W-1:0] wave_sel_shadow;
   int                            phase_shadow;
   tick_type                      expected_ticks [$];
   int                            fail_count;
   int                            send_idle_pct;
   int                            recv_idle_pct;
   int                            hold_request;
   row_type                       directed_rows [17];

   multi_shape_waveform_generator_top #(
      .SAMPLES_PER_PERIOD (PERIOD_LEN),
      .AMPLITUDE          (AMP)
   ) i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_restart    (req_restart),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_sample     (rsp_sample),
      .rsp_phase      (rsp_phase),
      .rsp_period_end (rsp_period_end),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data)
   );

   function automatic logic [mswg_pkg::SAMPLE_W-1:0] sine_at(input int idx);
      longint unsigned turn;
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint unsigned num;
      longint unsigned code;
      longint          acc;
      longint          biased;
      bit              negative;
      turn = (64'(idx) << 32) / 64'(PERIOD_LEN);
      negative = 1'b0;
      if (turn >= (64'd1 << 31)) begin
         negative = 1'b1;
         turn = turn - (64'd1 << 31);
      end
      if (turn > (64'd1 << 30)) begin
         turn = (64'd1 << 31) - turn;
      end
      x = (turn * PI_FIX) >> 31;
      x2 = (x * x) >> 30;
      term = x;
      acc = longint'(term);
      for (int k = 1; k <= 7; k++) begin
         term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
         if (k % 2 == 1) begin
            acc = acc - longint'(term);
         end else begin
            acc = acc + longint'(term);
         end
      end
      if (acc < 0) begin
         acc = 0;
      end
      if (acc > longint'(UNIT_FIX)) begin
         acc = longint'(UNIT_FIX);
      end
      if (negative) begin
         acc = -acc;
      end
      biased = longint'(UNIT_FIX) + acc;
      num = 64'(biased) * 64'(AMP);
      code = (num + UNIT_FIX) >> 31;
      if (code > 64'd255) begin
         code = 64'd255;
      end
      return code[mswg_pkg::SAMPLE_W-1:0];
   endfunction

   task automatic predict_tick(input bit restart_bit, output tick_type r);
      int idx;
      int level;
      if (restart_bit) begin
         phase_shadow = 0;
      end
      idx = phase_shadow % PERIOD_LEN;
      unique case (wave_sel_shadow)
         mswg_pkg::WAVE_SINE: level = sine_codes[idx];
         mswg_pkg::WAVE_TRIANGLE: begin
            level = (idx > PERIOD_LEN / 2) ? (2 * AMP * (PERIOD_LEN - idx)) / PERIOD_LEN
                                           : (2 * AMP * idx) / PERIOD_LEN;
         end
         mswg_pkg::WAVE_SAWTOOTH: level = (idx * AMP) / PERIOD_LEN;
         mswg_pkg::WAVE_SQUARE: level = (idx < PERIOD_LEN / 2) ? AMP : 0;
         default: level = 0;
      endcase
      r.sample = level[mswg_pkg::SAMPLE_W-1:0];
      r.phase = idx[mswg_pkg::PHASE_W-1:0];
      r.period_end = (idx == PERIOD_LEN - 1);
      phase_shadow = (idx + 1 >= PERIOD_LEN) ? 0 : idx + 1;
   endtask

   task automatic send_word(input bit restart_bit, input bit use_typed, input tick_type typed_val);
      tick_type predicted;
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_restart <= restart_bit;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
      predict_tick(restart_bit, predicted);
      expected_ticks.push_back(use_typed ? typed_val : predicted);
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_ticks.size() != 0) begin
         @(posedge clock);
      end
      repeat (4) @(posedge clock);
   endtask

   task automatic write_select(input logic [mswg_pkg::SELECT_W-1:0] sel);
      wait_drained();
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= sel;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      wave_sel_shadow = sel;
   endtask

   initial begin
      clock = 1'b0;
      forever begin
         #6 clock = ~clock;
      end
   end

   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request > 0) begin
            int n;
            n = hold_request;
            hold_request = 0;
            rsp_ready <= 1'b0;
            repeat (n - 1) @(negedge clock);
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_ticks.size() == 0) begin
            $display("%0t: unexpected word sample %0d phase %0d period_end %0d",
                     $time, rsp_sample, rsp_phase, rsp_period_end);
            fail_count++;
         end else begin
            tick_type want;
            want = expected_ticks.pop_front();
            if (rsp_sample !== want.sample) begin
               $display("%0t: sample expected %0d actual %0d", $time, want.sample, rsp_sample);
               fail_count++;
            end
            if (rsp_phase !== want.phase) begin
               $display("%0t: phase expected %0d actual %0d", $time, want.phase, rsp_phase);
               fail_count++;
            end
            if (rsp_period_end !== want.period_end) begin
               $display("%0t: period_end expected %0d actual %0d",
                        $time, want.period_end, rsp_period_end);
               fail_count++;
            end
         end
      end
   end

   initial begin
      #1200000;
      $display("FAILURE");
      $finish;
   end

   initial begin
      int seg_no;
      logic [mswg_pkg::SELECT_W-1:0] seg_sel;
      reset = 1'b1;
      req_valid = 1'b0;
      req_restart = 1'b0;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      fail_count = 0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_request = 0;
      phase_shadow = 0;
      wave_sel_shadow = mswg_pkg::WAVE_ZERO;
      for (int i = 0; i < PERIOD_LEN; i++) begin
         sine_codes[i] = sine_at(i);
      end
      directed_rows = '{
         '{1'b0, mswg_pkg::WAVE_ZERO,     1'b0, 1'b1, 8'd0,   12'd0, 1'b0},
         '{1'b0, mswg_pkg::WAVE_ZERO,     1'b1, 1'b1, 8'd0,   12'd0, 1'b0},
         '{1'b1, mswg_pkg::WAVE_SINE,     1'b1, 1'b1, 8'd128, 12'd0, 1'b0},
         '{1'b0, mswg_pkg::WAVE_SINE,     1'b0, 1'b0, 8'd0,   12'd0, 1'b0},
         '{1'b1, mswg_pkg::WAVE_TRIANGLE, 1'b0, 1'b0, 8'd0,   12'd0, 1'b0},
         '{1'b1, mswg_pkg::WAVE_SQUARE,   1'b1, 1'b1, 8'd255, 12'd0, 1'b0},
         '{1'b0, mswg_pkg::WAVE_SQUARE,   1'b0, 1'b1, 8'd255, 12'd1, 1'b0},
         '{1'b1, mswg_pkg::WAVE_SAWTOOTH, 1'b1, 1'b1, 8'd0,   12'd0, 1'b0},
         '{1'b0, mswg_pkg::WAVE_SAWTOOTH, 1'b0, 1'b0, 8'd0,   12'd0, 1'b0},
         '{1'b1, SEL_SPARE_LO,            1'b0, 1'b1, 8'd0,   12'd2, 1'b0},
         '{1'b1, SEL_SPARE_MID,           1'b1, 1'b1, 8'd0,   12'd0, 1'b0},
         '{1'b1, SEL_SPARE_HI,            1'b0, 1'b1, 8'd0,   12'd1, 1'b0},
         '{1'b1, mswg_pkg::WAVE_ZERO,     1'b0, 1'b1, 8'd0,   12'd2, 1'b0},
         '{1'b1, mswg_pkg::WAVE_TRIANGLE, 1'b1, 1'b1, 8'd0,   12'd0, 1'b0},
         '{1'b0, mswg_pkg::WAVE_TRIANGLE, 1'b0, 1'b0, 8'd0,   12'd0, 1'b0},
         '{1'b1, mswg_pkg::WAVE_SINE,     1'b0, 1'b0, 8'd0,   12'd0, 1'b0},
         '{1'b0, mswg_pkg::WAVE_SINE,     1'b1, 1'b1, 8'd128, 12'd0, 1'b0}
      };
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[r]) begin
         if (directed_rows[r].write_sel) begin
            write_select(directed_rows[r].sel);
         end
         send_word(directed_rows[r].restart, directed_rows[r].typed,
                   {directed_rows[r].sample, directed_rows[r].phase,
                    directed_rows[r].period_end});
      end

      seg_no = 0;
      for (int p = 0; p < 3; p++) begin
         send_idle_pct = (p == 0) ? 6 : (p == 1) ? 57 : 0;
         recv_idle_pct = (p == 0) ? 57 : (p == 1) ? 6 : 0;
         for (int s = 0; s < 4; s++) begin
            seg_sel = (seg_no < 8) ? seg_no[mswg_pkg::SELECT_W-1:0]
                                   : mswg_pkg::SELECT_W'($urandom_range(7));
            write_select(seg_sel);
            if (p == 2 && s == 0) begin
               hold_request = HOLD_CYCLES;
            end
            for (int n = 0; n < 108; n++) begin
               if (p == 1 && s == 1 && n == 54) begin
                  wait_drained();
               end
               send_word($urandom_range(299) == 0, 1'b0, '0);
            end
            seg_no++;
         end
      end

      wait_drained();
      repeat (10) @(posedge clock);
      if (fail_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
